### src/lsfd_pkg.sv
package lsfd_pkg;

  // Frame marker bytes
  localparam logic [7:0] HDR_BYTE0 = 8'hFE;
  localparam logic [7:0] HDR_BYTE1 = 8'hFF;
  localparam logic [7:0] TRL_BYTE0 = 8'hCC;
  localparam logic [7:0] TRL_BYTE1 = 8'hDD;

  // One full turn in hundredths of a degree
  localparam int unsigned FULL_TURN = 36000;

  // Field widths
  localparam int unsigned CFG_DATA_W  = 17;
  localparam int unsigned CFG_INDEX_W = 3;

  // Register indexes of the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WINDOW_LOW   = 3'd0,
    REG_WINDOW_HIGH  = 3'd1,
    REG_RANGE_MIN_MM = 3'd2,
    REG_RANGE_MAX_MM = 3'd3
  } reg_index_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_POINT    = 2'd0,
    KIND_END_GOOD = 2'd1,
    KIND_END_BAD  = 2'd2
  } kind_e;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_HDR2 = 3'd1,
    PH_CNTH = 3'd2,
    PH_CNTL = 3'd3,
    PH_PNTS = 3'd4,
    PH_TRL1 = 3'd5,
    PH_TRL2 = 3'd6
  } phase_e;

  // Filter settings
  typedef struct packed {
    logic [15:0] window_low;
    logic [16:0] window_high;
    logic [15:0] range_min_mm;
    logic [15:0] range_max_mm;
  } filter_cfg_t;

endpackage

### src/lsfd_filter.sv
module lsfd_filter
  import lsfd_pkg::*;
(
  input  filter_cfg_t cfg_i,
  input  logic [15:0] angle_i,
  input  logic [15:0] range_i,
  output logic        masked_o
);

  logic signed [18:0] dist_s;
  logic signed [18:0] low_s;
  logic signed [18:0] high_s;
  logic signed [18:0] high_wrap_s;
  logic               wrapped;
  logic               angle_masked;
  logic               range_masked;

  // Angle window test on the mirrored angle (full turn minus angle)
  always_comb begin
    dist_s      = $signed(19'(FULL_TURN)) - $signed({3'b000, angle_i});
    low_s       = $signed({3'b000, cfg_i.window_low});
    high_s      = $signed({2'b00, cfg_i.window_high});
    high_wrap_s = high_s - $signed(19'(FULL_TURN));
    wrapped     = cfg_i.window_high > 17'(FULL_TURN);
    if (wrapped) begin
      angle_masked = (dist_s > high_wrap_s) && (dist_s < low_s);
    end else begin
      angle_masked = (dist_s > high_s) || (dist_s < low_s);
    end
  end

  // Range limits
  assign range_masked = (range_i < cfg_i.range_min_mm) || (range_i > cfg_i.range_max_mm);

  assign masked_o = angle_masked || range_masked;

endmodule

### src/lidar_scan_frame_deframer_unit.sv
// Scan-frame deframer for a serial lidar byte stream. Bytes enter on the rx
// channel; the unit hunts for header FE FF, reads a big-endian 16-bit point
// count, then four bytes per point (angle in centidegrees, range in mm) and a
// CC DD trailer. Each point leaves as one transaction when its fourth byte
// arrives, with range_mm forced to 0 when the point is outside the angle
// window or the range limits; after the trailer one end transaction (last_o
// high) reports the frame good or bad. Points go out before the trailer is
// checked, so a consumer must drop the points of a frame that ends bad.
// Throughput is one byte per cycle while results are taken: a byte register
// feeds the parser and filter, whose result lands in an output register; a
// byte that yields a result waits in the byte register only while the output
// register holds an untaken result. Configuration is written through the cfg
// port, by the user only while the unit is idle, which the unit itself does
// not enforce; indexes above 3 are ignored.
module lidar_scan_frame_deframer_unit
  import lsfd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration writes
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // byte stream in
  input  logic                   rx_valid_i,
  output logic                   rx_ready_o,
  input  logic [7:0]             rx_byte_i,
  // results out
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             kind_o,
  output logic [15:0]            point_index_o,
  output logic [15:0]            angle_centideg_o,
  output logic [15:0]            range_mm_o,
  output logic [15:0]            point_total_o,
  output logic                   last_o
);

  filter_cfg_t cfg_q;

  logic       byte_valid_q;
  logic [7:0] byte_q;

  phase_e      phase_q, phase_d;
  logic [1:0]  bip_q, bip_d;
  logic [15:0] announced_q, announced_d;
  logic [15:0] seen_q, seen_d;
  logic [15:0] held_angle_q, held_angle_d;
  logic [7:0]  held_high_q, held_high_d;
  logic        trl_ok_q, trl_ok_d;

  logic        out_valid_q;
  kind_e       kind_q, kind_d;
  logic [15:0] index_q, index_d;
  logic [15:0] angle_q, angle_d;
  logic [15:0] range_q, range_d;
  logic [15:0] total_q, total_d;
  logic        last_q, last_d;

  logic        emit;
  logic        advance;
  logic        out_free;
  logic [15:0] word;
  logic [15:0] seen_inc;
  logic        masked;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_low   <= 16'd0;
      cfg_q.window_high  <= 17'(FULL_TURN);
      cfg_q.range_min_mm <= 16'd300;
      cfg_q.range_max_mm <= 16'hFFFF;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_WINDOW_LOW:   cfg_q.window_low   <= cfg_data_i[15:0];
        REG_WINDOW_HIGH:  cfg_q.window_high  <= cfg_data_i;
        REG_RANGE_MIN_MM: cfg_q.range_min_mm <= cfg_data_i[15:0];
        REG_RANGE_MAX_MM: cfg_q.range_max_mm <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Handshake: the byte register drains when its result (if any) has a slot
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = byte_valid_q && (!emit || out_free);
  assign rx_ready_o = !byte_valid_q || advance;

  // Input byte register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
    end else if (rx_ready_o) begin
      byte_valid_q <= rx_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_valid_i && rx_ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

  assign word     = {held_high_q, byte_q};
  assign seen_inc = seen_q + 16'd1;

  lsfd_filter u_filter (
    .cfg_i    (cfg_q),
    .angle_i  (held_angle_q),
    .range_i  (word),
    .masked_o (masked)
  );

  // Parser next state and result
  always_comb begin
    phase_d      = phase_q;
    bip_d        = bip_q;
    announced_d  = announced_q;
    seen_d       = seen_q;
    held_angle_d = held_angle_q;
    held_high_d  = held_high_q;
    trl_ok_d     = trl_ok_q;
    emit         = 1'b0;
    kind_d       = KIND_POINT;
    index_d      = seen_q;
    angle_d      = held_angle_q;
    range_d      = masked ? 16'd0 : word;
    total_d      = announced_q;
    last_d       = 1'b0;
    case (phase_q)
      PH_HUNT: begin
        if (byte_q == HDR_BYTE0) phase_d = PH_HDR2;
      end
      PH_HDR2: begin
        if (byte_q == HDR_BYTE1) begin
          phase_d = PH_CNTH;
        end else if (byte_q != HDR_BYTE0) begin
          phase_d = PH_HUNT;
        end
      end
      PH_CNTH: begin
        held_high_d = byte_q;
        phase_d     = PH_CNTL;
      end
      PH_CNTL: begin
        announced_d = word;
        seen_d      = 16'd0;
        bip_d       = 2'd0;
        phase_d     = (word == 16'd0) ? PH_TRL1 : PH_PNTS;
      end
      PH_PNTS: begin
        case (bip_q)
          2'd1: held_angle_d = word;
          2'd3: begin
            emit   = 1'b1;
            seen_d = seen_inc;
            if (seen_inc == announced_q) phase_d = PH_TRL1;
          end
          default: held_high_d = byte_q;
        endcase
        bip_d = bip_q + 2'd1;
      end
      PH_TRL1: begin
        trl_ok_d = (byte_q == TRL_BYTE0);
        phase_d  = PH_TRL2;
      end
      PH_TRL2: begin
        emit    = 1'b1;
        kind_d  = (trl_ok_q && byte_q == TRL_BYTE1) ? KIND_END_GOOD : KIND_END_BAD;
        angle_d = 16'd0;
        range_d = 16'd0;
        last_d  = 1'b1;
        phase_d = PH_HUNT;
      end
      default: phase_d = PH_HUNT;
    endcase
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      bip_q        <= 2'd0;
      announced_q  <= 16'd0;
      seen_q       <= 16'd0;
      held_angle_q <= 16'd0;
      held_high_q  <= 8'd0;
      trl_ok_q     <= 1'b0;
    end else if (advance) begin
      phase_q      <= phase_d;
      bip_q        <= bip_d;
      announced_q  <= announced_d;
      seen_q       <= seen_d;
      held_angle_q <= held_angle_d;
      held_high_q  <= held_high_d;
      trl_ok_q     <= trl_ok_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      kind_q  <= kind_d;
      index_q <= index_d;
      angle_q <= angle_d;
      range_q <= range_d;
      total_q <= total_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign point_index_o    = index_q;
  assign angle_centideg_o = angle_q;
  assign range_mm_o       = range_q;
  assign point_total_o    = total_q;
  assign last_o           = last_q;

  // End results never carry the point kind
  a_end_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> kind_o != KIND_POINT)
    else $error("end result with point kind");

  // A point result lies inside the announced count
  a_point_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> kind_o == KIND_POINT && point_index_o < point_total_o)
    else $error("point result out of frame");

  // While reading points, fewer points than announced have gone out
  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PNTS |-> seen_q < announced_q)
    else $error("point counter past announced count");

  // A result is produced only on the fourth point byte or second trailer byte
  a_emit_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit |-> (phase_q == PH_PNTS && bip_q == 2'd3) || phase_q == PH_TRL2)
    else $error("result emitted in wrong phase");

endmodule
